/* sv/gbe_pkg.sv */
// Shared types and constants for the bilinear elevation grid block.
package gbe_pkg;

   localparam int MAX_SIDE_DEFAULT  = 1024;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int SIDE_W     = 11;
   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 20;
   localparam int ELEV_W     = 24;
   localparam int OUTQ_DEPTH = 4;

   localparam logic [SIDE_W-1:0]   GRID_SIDE_RESET = 11'd1024;
   localparam logic [SAMPLE_W-1:0] VOID_SAMPLE     = 16'h8000;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_GRID_SIDE  = 1'b0,
      REG_TILE_VALID = 1'b1
   } reg_index_type;

   // corner read order: (x0,y0), (x0+1,y0), (x0,y0+1), (x0+1,y0+1)
   typedef enum logic [1:0] {
      CORNER_00 = 2'd0,
      CORNER_10 = 2'd1,
      CORNER_01 = 2'd2,
      CORNER_11 = 2'd3
   } corner_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic                        tile_ok;
      logic                        write_ok;
      logic [SIDE_W-1:0]           side;
      logic signed [SAMPLE_W-1:0]  elev;
   } desc_type;

   typedef struct packed {
      logic       valid;
      corner_type corner;
      logic       tile_ok;
   } corner_ctl_type;

   typedef struct packed {
      logic signed [ELEV_W-1:0] elevation_fixed;
      logic                     result_valid;
   } result_type;

endpackage

/* sv/gbe_addr.sv */
// Front pipeline: grid coordinates, clamping, weights and sample address.
module gbe_addr #(
   parameter int MAX_SIDE  = gbe_pkg::MAX_SIDE_DEFAULT,
   parameter int FRAC_BITS = gbe_pkg::FRAC_BITS_DEFAULT,
   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [gbe_pkg::SIDE_W-1:0]          grid_side,
   input  logic                                tile_valid,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [gbe_pkg::INDEX_W-1:0]         req_write_index,
   input  logic signed [gbe_pkg::SAMPLE_W-1:0] req_write_elevation,
   input  logic [15:0]                         req_lat_fraction,
   input  logic [15:0]                         req_lon_fraction,
   output logic                                desc_valid,
   input  logic                                desc_ready,
   output gbe_pkg::desc_type                   desc,
   output logic [AW-1:0]                       desc_addr,
   output logic [FRAC_BITS:0]                  desc_dx,
   output logic [FRAC_BITS:0]                  desc_dy
);

   localparam int SW = gbe_pkg::SIDE_W;
   localparam int FB = FRAC_BITS;
   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

   logic s1_en, s2_en, s3_en;
   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;

   // stage 1
   gbe_pkg::cmd_type                     s1_cmd_ff;
   logic [gbe_pkg::INDEX_W-1:0]          s1_idx_ff;
   logic signed [gbe_pkg::SAMPLE_W-1:0]  s1_elev_ff;
   logic [15:0]                          s1_lat_ff, s1_lon_ff;

   // stage 2
   gbe_pkg::cmd_type                     s2_cmd_ff;
   logic [gbe_pkg::INDEX_W-1:0]          s2_idx_ff;
   logic signed [gbe_pkg::SAMPLE_W-1:0]  s2_elev_ff;
   logic [SW-1:0]                        s2_side_ff;
   logic [2*SW-1:0]                      s2_sq_ff;
   logic [FB+SW-1:0]                     s2_x_ff;
   logic [FB+SW:0]                       s2_y_ff;
   logic                                 s2_tv_ff;

   // stage 3
   gbe_pkg::cmd_type                     s3_cmd_ff;
   logic [gbe_pkg::INDEX_W-1:0]          s3_idx_ff;
   logic signed [gbe_pkg::SAMPLE_W-1:0]  s3_elev_ff;
   logic [SW-1:0]                        s3_side_ff, s3_x0_ff, s3_y0_ff;
   logic [FB:0]                          s3_dx_ff, s3_dy_ff;
   logic                                 s3_tv_ff, s3_wok_ff;

   // stage 1 logic
   logic [SW-1:0]     side, side_m1;
   logic [FB+15:0]    lat_w, lon_w;
   logic [FB-1:0]     lat_s, lon_s;
   logic [FB:0]       lat_inv;
   logic [FB+SW-1:0]  x_in;
   logic [FB+SW:0]    y_in;
   logic [2*SW-1:0]   sq_in;

   // stage 2 logic
   logic [SW-1:0]     side_m2, x_int, x0_in, y0_in;
   logic [SW:0]       y_int;
   logic [FB+SW-1:0]  dx_full;
   logic [FB+SW:0]    dy_full;
   logic [FB:0]       dx_in, dy_in;
   logic              wok_in;

   // stage 3 logic
   logic [2*SW-1:0]   base_prod, base_sum;

   assign s3_en     = !s3_v_ff || desc_ready;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_ready = s1_en;

   assign s1_v_in = s1_en ? req_valid : s1_v_ff;
   assign s2_v_in = s2_en ? s1_v_ff : s2_v_ff;
   assign s3_v_in = s3_en ? s2_v_ff : s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   // side in use: below 2 acts as 2, above MAX_SIDE as MAX_SIDE
   always_comb begin
      if (grid_side < SW'(2)) begin
         side = SW'(2);
      end else if (32'(grid_side) > MAX_SIDE) begin
         side = SW'(MAX_SIDE);
      end else begin
         side = grid_side;
      end
   end

   assign side_m1 = side - SW'(1);
   assign lat_w   = {s1_lat_ff, {FB{1'b0}}};
   assign lon_w   = {s1_lon_ff, {FB{1'b0}}};
   assign lat_s   = lat_w[FB+15:16];
   assign lon_s   = lon_w[FB+15:16];
   assign lat_inv = ONE - {1'b0, lat_s};
   assign x_in    = lon_s * side_m1;
   assign y_in    = lat_inv * side_m1;
   assign sq_in   = side * side;

   // base cell clamped to side-2; the weight may then reach one
   assign side_m2 = s2_side_ff - SW'(2);
   assign x_int   = s2_x_ff[FB+SW-1:FB];
   assign y_int   = s2_y_ff[FB+SW:FB];
   assign x0_in   = (x_int > side_m2) ? side_m2 : x_int;
   assign y0_in   = (y_int > {1'b0, side_m2}) ? side_m2 : y_int[SW-1:0];
   assign dx_full = s2_x_ff - {x0_in, {FB{1'b0}}};
   assign dy_full = s2_y_ff - {1'b0, y0_in, {FB{1'b0}}};
   assign dx_in   = dx_full[FB:0];
   assign dy_in   = dy_full[FB:0];
   assign wok_in  = (2*SW)'(s2_idx_ff) < s2_sq_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_cmd_ff  <= gbe_pkg::cmd_type'(req_command);
         s1_idx_ff  <= req_write_index;
         s1_elev_ff <= req_write_elevation;
         s1_lat_ff  <= req_lat_fraction;
         s1_lon_ff  <= req_lon_fraction;
      end
      if (s2_en) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_elev_ff <= s1_elev_ff;
         s2_side_ff <= side;
         s2_sq_ff   <= sq_in;
         s2_x_ff    <= x_in;
         s2_y_ff    <= y_in;
         s2_tv_ff   <= tile_valid;
      end
      if (s3_en) begin
         s3_cmd_ff  <= s2_cmd_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_elev_ff <= s2_elev_ff;
         s3_side_ff <= s2_side_ff;
         s3_x0_ff   <= x0_in;
         s3_y0_ff   <= y0_in;
         s3_dx_ff   <= dx_in;
         s3_dy_ff   <= dy_in;
         s3_tv_ff   <= s2_tv_ff;
         s3_wok_ff  <= wok_in;
      end
   end

   assign base_prod = s3_y0_ff * s3_side_ff;
   assign base_sum  = base_prod + (2*SW)'(s3_x0_ff);

   assign desc_valid    = s3_v_ff;
   assign desc.cmd      = s3_cmd_ff;
   assign desc.tile_ok  = s3_tv_ff;
   assign desc.write_ok = s3_wok_ff;
   assign desc.side     = s3_side_ff;
   assign desc.elev     = s3_elev_ff;
   assign desc_addr     = (s3_cmd_ff == gbe_pkg::CMD_WRITE) ? AW'(s3_idx_ff) : AW'(base_sum);
   assign desc_dx       = s3_dx_ff;
   assign desc_dy       = s3_dy_ff;

endmodule

/* sv/gbe_store.sv */
// Sample memory and access sequencer: one write, or four corner reads per query.
module gbe_store #(
   parameter int MAX_SIDE  = gbe_pkg::MAX_SIDE_DEFAULT,
   parameter int FRAC_BITS = gbe_pkg::FRAC_BITS_DEFAULT,
   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                desc_valid,
   output logic                                desc_ready,
   input  gbe_pkg::desc_type                   desc,
   input  logic [AW-1:0]                       desc_addr,
   input  logic [FRAC_BITS:0]                  desc_dx,
   input  logic [FRAC_BITS:0]                  desc_dy,
   input  logic                                room,
   output logic                                reserve,
   output gbe_pkg::corner_ctl_type             rd_ctl,
   output logic signed [gbe_pkg::SAMPLE_W-1:0] rd_sample,
   output logic [FRAC_BITS:0]                  rd_dx,
   output logic [FRAC_BITS:0]                  rd_dy
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int SW    = gbe_pkg::SIDE_W;

   logic [gbe_pkg::SAMPLE_W-1:0] mem [DEPTH];

   logic                    cur_v_ff, cur_v_in;
   gbe_pkg::desc_type       cur_ff;
   logic [AW-1:0]           cur_addr_ff;
   logic [FRAC_BITS:0]      cur_dx_ff, cur_dy_ff;
   gbe_pkg::corner_type     phase_ff, phase_in;

   logic                    cur_done, load, mem_we, mem_re;
   logic [SW:0]             offset;
   logic [AW-1:0]           mem_addr;

   gbe_pkg::corner_ctl_type      rd_ctl_ff;
   logic [gbe_pkg::SAMPLE_W-1:0] rd_sample_ff;
   logic [FRAC_BITS:0]           rd_dx_ff, rd_dy_ff;

   assign cur_done = cur_v_ff && (cur_ff.cmd == gbe_pkg::CMD_WRITE ||
                                  phase_ff == gbe_pkg::CORNER_11);
   // a query takes a result slot up front so the read stream never stalls
   assign desc_ready = (!cur_v_ff || cur_done) &&
                       (desc.cmd == gbe_pkg::CMD_WRITE || room);
   assign load       = desc_valid && desc_ready;
   assign reserve    = load && desc.cmd == gbe_pkg::CMD_QUERY;

   assign cur_v_in = load ? 1'b1 : (cur_done ? 1'b0 : cur_v_ff);

   always_comb begin
      phase_in = phase_ff;
      if (load) begin
         phase_in = gbe_pkg::CORNER_00;
      end else if (mem_re) begin
         phase_in = gbe_pkg::corner_type'(phase_ff + 2'd1);
      end
   end

   always_comb begin
      unique case (phase_ff)
         gbe_pkg::CORNER_00: offset = '0;
         gbe_pkg::CORNER_10: offset = (SW+1)'(1);
         gbe_pkg::CORNER_01: offset = {1'b0, cur_ff.side};
         gbe_pkg::CORNER_11: offset = {1'b0, cur_ff.side} + (SW+1)'(1);
      endcase
   end

   assign mem_addr = cur_addr_ff + AW'(offset);
   assign mem_we   = cur_v_ff && cur_ff.cmd == gbe_pkg::CMD_WRITE && cur_ff.write_ok;
   assign mem_re   = cur_v_ff && cur_ff.cmd == gbe_pkg::CMD_QUERY;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff        <= 1'b0;
         phase_ff        <= gbe_pkg::CORNER_00;
         rd_ctl_ff.valid <= 1'b0;
      end else begin
         cur_v_ff        <= cur_v_in;
         phase_ff        <= phase_in;
         rd_ctl_ff.valid <= mem_re;
      end
      rd_ctl_ff.corner  <= phase_ff;
      rd_ctl_ff.tile_ok <= cur_ff.tile_ok;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff      <= desc;
         cur_addr_ff <= desc_addr;
         cur_dx_ff   <= desc_dx;
         cur_dy_ff   <= desc_dy;
      end
      rd_dx_ff <= cur_dx_ff;
      rd_dy_ff <= cur_dy_ff;
   end

   // single port, in issue order, so a read always sees earlier writes
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= cur_ff.elev;
      end
      rd_sample_ff <= mem[mem_addr];
   end

   assign rd_ctl    = rd_ctl_ff;
   assign rd_sample = $signed(rd_sample_ff);
   assign rd_dx     = rd_dx_ff;
   assign rd_dy     = rd_dy_ff;

`ifndef SYNTHESIS
   a_write_single_phase: assert property (@(posedge clock) disable iff (reset)
      (cur_v_ff && cur_ff.cmd == gbe_pkg::CMD_WRITE) |-> phase_ff == gbe_pkg::CORNER_00)
      else $error("write transaction left the first phase");
   a_corner_burst: assert property (@(posedge clock) disable iff (reset)
      (rd_ctl_ff.valid && rd_ctl_ff.corner != gbe_pkg::CORNER_11) |=>
      (rd_ctl_ff.valid &&
       rd_ctl_ff.corner == gbe_pkg::corner_type'($past(rd_ctl_ff.corner) + 2'd1)))
      else $error("corner reads of a query not issued back to back");
`endif

endmodule

/* sv/gbe_interp.sv */
// Bilinear accumulation of the four corner samples and truncation to 8 fraction bits.
module gbe_interp #(
   parameter int FRAC_BITS = gbe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gbe_pkg::corner_ctl_type             rd_ctl,
   input  logic signed [gbe_pkg::SAMPLE_W-1:0] rd_sample,
   input  logic [FRAC_BITS:0]                  rd_dx,
   input  logic [FRAC_BITS:0]                  rd_dy,
   output logic                                push,
   output gbe_pkg::result_type                 push_data
);

   localparam int FB    = FRAC_BITS;
   localparam int SMW   = gbe_pkg::SAMPLE_W;
   localparam int WW    = 2 * FB + 1;
   localparam int LW    = (WW + 1) / 2;
   localparam int HW    = WW - LW;
   localparam int ACC_W = 2 * FB + 17;
   localparam int SHIFT = 2 * FB - 8;
   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

   logic [FB:0]        wx, wy;
   logic [2*FB+1:0]    w_full;

   gbe_pkg::corner_ctl_type  p1_ctl_ff, p2_ctl_ff;
   logic signed [SMW-1:0]    p1_sample_ff;
   logic [WW-1:0]            p1_w_ff;
   logic                     p1_void_ff, p2_void_ff;

   logic signed [LW:0]       w_lo;
   logic signed [HW:0]       w_hi;
   logic signed [SMW+LW:0]   pl_in, pl_ff;
   logic signed [SMW+HW:0]   ph_in, ph_ff;

   logic signed [ACC_W-1:0]  term, acc_in, acc_ff, sum_ff;
   logic                     first, last, void_in, void_acc_ff;
   logic                     done_ff, ok_ff;

   logic signed [ACC_W-1:0]  bias, biased, shifted;

   assign wx = (rd_ctl.corner == gbe_pkg::CORNER_10 || rd_ctl.corner == gbe_pkg::CORNER_11)
               ? rd_dx : ONE - rd_dx;
   assign wy = (rd_ctl.corner == gbe_pkg::CORNER_01 || rd_ctl.corner == gbe_pkg::CORNER_11)
               ? rd_dy : ONE - rd_dy;
   assign w_full = wx * wy;

   // weight split in halves keeps each product to the sample width plus half the weight width
   assign w_lo  = {1'b0, p1_w_ff[LW-1:0]};
   assign w_hi  = {1'b0, p1_w_ff[WW-1:LW]};
   assign pl_in = p1_sample_ff * w_lo;
   assign ph_in = p1_sample_ff * w_hi;

   assign term    = (ACC_W'(ph_ff) <<< LW) + ACC_W'(pl_ff);
   assign first   = p2_ctl_ff.corner == gbe_pkg::CORNER_00;
   assign last    = p2_ctl_ff.valid && p2_ctl_ff.corner == gbe_pkg::CORNER_11;
   assign acc_in  = first ? term : acc_ff + term;
   assign void_in = (first ? 1'b0 : void_acc_ff) | p2_void_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff.valid <= 1'b0;
         p2_ctl_ff.valid <= 1'b0;
         done_ff         <= 1'b0;
      end else begin
         p1_ctl_ff.valid <= rd_ctl.valid;
         p2_ctl_ff.valid <= p1_ctl_ff.valid;
         done_ff         <= last;
      end
      p1_ctl_ff.corner  <= rd_ctl.corner;
      p1_ctl_ff.tile_ok <= rd_ctl.tile_ok;
      p2_ctl_ff.corner  <= p1_ctl_ff.corner;
      p2_ctl_ff.tile_ok <= p1_ctl_ff.tile_ok;
   end

   always_ff @(posedge clock) begin
      p1_sample_ff      <= rd_sample;
      p1_w_ff           <= w_full[WW-1:0];
      p1_void_ff        <= rd_sample == $signed(gbe_pkg::VOID_SAMPLE);
      p2_void_ff        <= p1_void_ff;
      pl_ff             <= pl_in;
      ph_ff             <= ph_in;
      if (p2_ctl_ff.valid) begin
         acc_ff      <= acc_in;
         void_acc_ff <= void_in;
      end
      if (last) begin
         sum_ff <= acc_in;
         ok_ff  <= p2_ctl_ff.tile_ok && !void_in;
      end
   end

   // truncate toward zero: negative sums get a bias of all ones below the cut
   assign bias    = {{(ACC_W-SHIFT){1'b0}}, {SHIFT{sum_ff[ACC_W-1]}}};
   assign biased  = sum_ff + bias;
   assign shifted = biased >>> SHIFT;

   assign push                      = done_ff;
   assign push_data.elevation_fixed = ok_ff ? shifted[gbe_pkg::ELEV_W-1:0] : '0;
   assign push_data.result_valid    = ok_ff;

endmodule

/* sv/gbe_outq.sv */
// Result queue with slot reservation, decoupling the read stream from rsp stalls.
module gbe_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                reserve,
   output logic                room,
   input  logic                push,
   input  gbe_pkg::result_type push_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gbe_pkg::result_type rsp_data
);

   localparam int DEPTH = gbe_pkg::OUTQ_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = PW + 1;

   gbe_pkg::result_type q_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       fill_ff, fill_in, credit_ff, credit_in;
   logic                pop;

   assign rsp_valid = fill_ff != '0;
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign room      = credit_ff < CW'(DEPTH);

   assign wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
   assign fill_in   = fill_ff + CW'(push) - CW'(pop);
   assign credit_in = credit_ff + CW'(reserve) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_fill_within_credit: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= credit_ff)
      else $error("result queue holds more entries than reserved slots");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff < CW'(DEPTH) || pop))
      else $error("result pushed into a full queue");
`endif

endmodule

/* sv/grid_bilinear_elevation.sv */
// Top level: bilinear elevation lookup on a square grid of 16-bit samples.
// Throughput: one write per cycle while the sequencer is free; a query holds the sequencer for
// its four corner reads on the single sample memory port, and waits for a free result slot.
// Reset clears the pipeline, queue and registers (grid_side 1024, tile_valid 0); samples stay
// undefined until written, with no clearing pass.
module grid_bilinear_elevation #(
   parameter int MAX_SIDE  = gbe_pkg::MAX_SIDE_DEFAULT,
   parameter int FRAC_BITS = gbe_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [gbe_pkg::INDEX_W-1:0]         req_write_index,
   input  logic signed [gbe_pkg::SAMPLE_W-1:0] req_write_elevation,
   input  logic [15:0]                         req_lat_fraction,
   input  logic [15:0]                         req_lon_fraction,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gbe_pkg::ELEV_W-1:0]   rsp_elevation_fixed,
   output logic                                rsp_result_valid,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int SW = gbe_pkg::SIDE_W;

   logic [SW-1:0] grid_side_ff, grid_side_in;
   logic          tile_valid_ff, tile_valid_in;
   logic          csr_write;

   logic                          desc_valid, desc_ready;
   gbe_pkg::desc_type             desc;
   logic [AW-1:0]                 desc_addr;
   logic [FRAC_BITS:0]            desc_dx, desc_dy;
   logic                          room, reserve;
   gbe_pkg::corner_ctl_type       rd_ctl;
   logic signed [gbe_pkg::SAMPLE_W-1:0] rd_sample;
   logic [FRAC_BITS:0]            rd_dx, rd_dy;
   logic                          push;
   gbe_pkg::result_type           push_data, rsp_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      grid_side_in  = grid_side_ff;
      tile_valid_in = tile_valid_ff;
      if (csr_write) begin
         unique case (paddr[2])
            gbe_pkg::REG_GRID_SIDE:  grid_side_in  = pwdata[SW-1:0];
            gbe_pkg::REG_TILE_VALID: tile_valid_in = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         gbe_pkg::REG_GRID_SIDE:  prdata = 32'(grid_side_ff);
         gbe_pkg::REG_TILE_VALID: prdata = 32'(tile_valid_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff  <= gbe_pkg::GRID_SIDE_RESET;
         tile_valid_ff <= 1'b0;
      end else begin
         grid_side_ff  <= grid_side_in;
         tile_valid_ff <= tile_valid_in;
      end
   end

   gbe_addr #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_addr (
      .clock               (clock),
      .reset               (reset),
      .grid_side           (grid_side_ff),
      .tile_valid          (tile_valid_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_write_index     (req_write_index),
      .req_write_elevation (req_write_elevation),
      .req_lat_fraction    (req_lat_fraction),
      .req_lon_fraction    (req_lon_fraction),
      .desc_valid          (desc_valid),
      .desc_ready          (desc_ready),
      .desc                (desc),
      .desc_addr           (desc_addr),
      .desc_dx             (desc_dx),
      .desc_dy             (desc_dy)
   );

   gbe_store #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc_ready (desc_ready),
      .desc       (desc),
      .desc_addr  (desc_addr),
      .desc_dx    (desc_dx),
      .desc_dy    (desc_dy),
      .room       (room),
      .reserve    (reserve),
      .rd_ctl     (rd_ctl),
      .rd_sample  (rd_sample),
      .rd_dx      (rd_dx),
      .rd_dy      (rd_dy)
   );

   gbe_interp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .rd_ctl    (rd_ctl),
      .rd_sample (rd_sample),
      .rd_dx     (rd_dx),
      .rd_dy     (rd_dy),
      .push      (push),
      .push_data (push_data)
   );

   gbe_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .reserve   (reserve),
      .room      (room),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_elevation_fixed = rsp_data.elevation_fixed;
   assign rsp_result_valid    = rsp_data.result_valid;

endmodule
